// File: rtl/zpconv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zpconv_pkg
// Shared types and constants of the zero-padded 2D convolution block.
// ----------------------------------------------------------------------------
package zpconv_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_KERNEL = 7;

    // Request kinds.
    localparam logic [1:0] KIND_COEF  = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KERNEL_ROWS  = 2'd2;
    localparam logic [1:0] REG_KERNEL_COLS  = 2'd3;

    localparam int CFG_DATA_W = 9;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [15:0] value;
    } item_t;

    typedef struct packed {
        logic signed [23:0] sum_value;
        logic               saturated;
    } result_t;

    // Control that travels with one kernel tap through the MAC pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic in_frame;
    } tap_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/zpconv_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zpconv_mac
// Multiply-accumulate over the taps of one query, then round half up to
// Q10.14 and saturate to 24 bits.
// ----------------------------------------------------------------------------
module zpconv_mac
    import zpconv_pkg::*;
#(
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tap_ctrl_t          tap,
    input  wire logic signed [15:0] pix,
    input  wire logic signed [15:0] coef,
    output      result_t            result,
    output      logic               done
);

    localparam int ACC_W = 32 + $clog2(MAX_KERNEL * MAX_KERNEL);
    localparam int SH_W  = ACC_W - 14;
    localparam int CMP_W = (SH_W > 25) ? SH_W : 25;
    localparam logic signed [CMP_W-1:0] SUM_MAX = CMP_W'(8388607);
    localparam logic signed [CMP_W-1:0] SUM_MIN = CMP_W'(-8388608);

    logic signed [31:0]      prod_reg, prod_next;
    tap_ctrl_t               prod_ctl_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    fin_reg;
    result_t                 result_reg, result_next;
    logic                    done_reg;

    logic signed [ACC_W-1:0] rnd;
    logic signed [SH_W-1:0]  shifted;
    logic signed [CMP_W-1:0] ext;

    always_comb
    begin
        prod_next = '0;
        if (tap.in_frame)
        begin
            prod_next = pix * coef;
        end
        acc_next  = (prod_ctl_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);
    end

    // Arithmetic shift gives floor((acc + 2^13) / 2^14) for either sign.
    always_comb
    begin
        rnd     = acc_reg + ACC_W'(8192);
        shifted = SH_W'(rnd >>> 14);
        ext     = CMP_W'(shifted);
        if (ext > SUM_MAX)
        begin
            result_next.sum_value = SUM_MAX[23:0];
            result_next.saturated = 1'b1;
        end
        else if (ext < SUM_MIN)
        begin
            result_next.sum_value = SUM_MIN[23:0];
            result_next.saturated = 1'b1;
        end
        else
        begin
            result_next.sum_value = ext[23:0];
            result_next.saturated = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctl_reg <= '0;
            fin_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_ctl_reg <= tap;
            fin_reg      <= prod_ctl_reg.valid && prod_ctl_reg.last;
            done_reg     <= fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (prod_ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (fin_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule
`default_nettype wire

// File: rtl/zero_padded_2d_convolution.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zero_padded_2d_convolution
// Single-channel 2D convolution with zero padding over a stored frame.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. Kind
// KIND_COEF writes one kernel coefficient and KIND_PIXEL one frame pixel;
// both leave busy low. KIND_QUERY raises busy and walks the kernel window
// one tap per cycle, reading the frame memory and the coefficient memory
// once per tap. The result appears on result with done high for one
// cycle, once the last tap has passed the MAC pipeline (an empty kernel
// sends one tap); busy stays high through the done cycle, so the next
// request is taken only after the done cycle ends.
// The receiver cannot stall: every done cycle must be taken.
// The user must write configuration through cfg_we / cfg_index / cfg_data
// only while the block is idle; the block itself does not enforce this.
// Reset restores the register defaults (256 x 256 frame, 3 x 3 kernel)
// and idles the sequencer; both memories are left as they are and must
// be written before they are read.
// ----------------------------------------------------------------------------
module zero_padded_2d_convolution
    import zpconv_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire item_t                 item,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output      result_t               result,
    output      logic                  done
);

    localparam int KW     = $clog2(MAX_KERNEL + 1);
    localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int FA_W   = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
    localparam int CDEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int CA_W   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int POS_W  = 8 + KW + 1;
    localparam logic [8:0] W_CAP = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);
    localparam logic [8:0] H_CAP = (MAX_HEIGHT > 511) ? 9'd511 : 9'(MAX_HEIGHT);
    localparam logic [2:0] K_CAP = (MAX_KERNEL > 7) ? 3'd7 : 3'(MAX_KERNEL);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_WAIT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [8:0] img_w_reg, img_h_reg;
    logic [2:0] krows_reg, kcols_reg;

    logic [7:0]    q_row_reg, q_col_reg;
    logic [KW-1:0] ki_reg, ki_next, kj_reg, kj_next;

    logic [15:0] frame_mem [FDEPTH];
    logic [15:0] coef_mem  [CDEPTH];
    logic [15:0] frame_q_reg, coef_q_reg;

    logic            accept, pix_we, coef_we;
    logic [FA_W-1:0] frame_waddr, frame_raddr;
    logic [CA_W-1:0] coef_waddr, coef_raddr;

    logic [8:0]       w_eff, h_eff;
    logic [KW-1:0]    kr, kc, rr, rc;
    logic             empty;
    logic [POS_W-1:0] pr, pc;
    logic             row_ok, col_ok;
    tap_ctrl_t        tap_now, tap_q_reg;

    // ------------------------------------------------------------------
    // Request decode and configuration.
    // ------------------------------------------------------------------
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign pix_we  = accept && (item.kind == KIND_PIXEL)
                     && (int'(item.row) < MAX_HEIGHT) && (int'(item.col) < MAX_WIDTH);
    assign coef_we = accept && (item.kind == KIND_COEF)
                     && (int'(item.row) < MAX_KERNEL) && (int'(item.col) < MAX_KERNEL);

    assign frame_waddr = FA_W'(int'(item.row) * MAX_WIDTH + int'(item.col));
    assign coef_waddr  = CA_W'(int'(item.row) * MAX_KERNEL + int'(item.col));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= 9'd256;
            img_h_reg <= 9'd256;
            krows_reg <= 3'd3;
            kcols_reg <= 3'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  img_w_reg <= cfg_data;
                REG_IMAGE_HEIGHT: img_h_reg <= cfg_data;
                REG_KERNEL_ROWS:  krows_reg <= cfg_data[2:0];
                REG_KERNEL_COLS:  kcols_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero image sizes act as one, oversize values clip.
    always_comb
    begin
        w_eff = (img_w_reg == 9'd0) ? 9'd1 : ((img_w_reg > W_CAP) ? W_CAP : img_w_reg);
        h_eff = (img_h_reg == 9'd0) ? 9'd1 : ((img_h_reg > H_CAP) ? H_CAP : img_h_reg);
        kr    = KW'((krows_reg > K_CAP) ? K_CAP : krows_reg);
        kc    = KW'((kcols_reg > K_CAP) ? K_CAP : kcols_reg);
        rr    = kr >> 1;
        rc    = kc >> 1;
        empty = (kr == '0) || (kc == '0);
    end

    // ------------------------------------------------------------------
    // Tap sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        pr     = POS_W'(q_row_reg) + POS_W'(ki_reg) - POS_W'(rr);
        pc     = POS_W'(q_col_reg) + POS_W'(kj_reg) - POS_W'(rc);
        row_ok = !pr[POS_W-1] && (pr < POS_W'(h_eff));
        col_ok = !pc[POS_W-1] && (pc < POS_W'(w_eff));

        // An empty kernel still sends one tap, forced outside, so the
        // accumulator sees a zero sum.
        tap_now.valid    = (state_reg == ST_ISSUE);
        tap_now.first    = (ki_reg == '0) && (kj_reg == '0);
        tap_now.last     = empty || ((ki_reg == kr - KW'(1)) && (kj_reg == kc - KW'(1)));
        tap_now.in_frame = !empty && row_ok && col_ok;

        frame_raddr = tap_now.in_frame ? FA_W'(int'(pr) * MAX_WIDTH + int'(pc)) : '0;
        coef_raddr  = CA_W'(int'(ki_reg) * MAX_KERNEL + int'(kj_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        ki_next    = ki_reg;
        kj_next    = kj_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.kind == KIND_QUERY))
                begin
                    state_next = ST_ISSUE;
                    ki_next    = '0;
                    kj_next    = '0;
                end
            end
            ST_ISSUE:
            begin
                if (tap_now.last)
                begin
                    state_next = ST_WAIT;
                end
                else if (kj_reg == kc - KW'(1))
                begin
                    kj_next = '0;
                    ki_next = ki_reg + KW'(1);
                end
                else
                begin
                    kj_next = kj_reg + KW'(1);
                end
            end
            ST_WAIT:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ki_reg    <= '0;
            kj_reg    <= '0;
            tap_q_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ki_reg    <= ki_next;
            kj_reg    <= kj_next;
            tap_q_reg <= tap_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.kind == KIND_QUERY))
        begin
            q_row_reg <= item.row;
            q_col_reg <= item.col;
        end
    end

    // ------------------------------------------------------------------
    // Memories. Writes happen only while idle; the read registers load in
    // every state, but only reads made while a query runs feed valid taps.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            frame_mem[frame_waddr] <= item.value;
        end
        frame_q_reg <= frame_mem[frame_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= item.value;
        end
        coef_q_reg <= coef_mem[coef_raddr];
    end

    zpconv_mac #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .tap    (tap_q_reg),
        .pix    (frame_q_reg),
        .coef   (coef_q_reg),
        .result (result),
        .done   (done)
    );

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_WAIT))
        else $error("result strobe outside the wait state");

    a_last_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ISSUE) && tap_now.last) |=> (state_reg == ST_WAIT))
        else $error("sequencer did not stop after the last tap");

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.kind == KIND_QUERY)) |=> (state_reg == ST_ISSUE))
        else $error("query request did not start the tap walk");

    a_raddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tap_now.valid && tap_now.in_frame) |-> (int'(frame_raddr) < FDEPTH))
        else $error("frame read address beyond the frame memory");

endmodule
`default_nettype wire
